// ===== rtl/qpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared widths, register codes, reset values and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package qpp_pkg;

    localparam int SAMPLE_BITS_DEF = 12;

    localparam int FS_BITS     = 13;
    localparam int RATIO_BITS  = 16;
    localparam int POS_BITS    = 14;
    localparam int POWER_BITS  = 20;
    localparam int POWER_SHIFT = 10;

    localparam logic [POWER_BITS-1:0] POWER_MAX   = 20'hFFFFF;
    localparam logic [FS_BITS-1:0]    FS_RESET    = 13'd5000;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd256;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_SCALE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POWER_RATIO = 1'b1;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_start;
        logic div_sel_y;
        logic take_x;
        logic take_y;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_zero;
        logic div_done;
    } t_dp_status;

endpackage

// ===== rtl/qpp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend is
// known to be below divisor * 2^QUO_BITS, so only QUO_BITS steps are run.
// ----------------------------------------------------------------------------
module qpp_div #(
    parameter int DVR_BITS = 14,
    parameter int QUO_BITS = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DVR_BITS+QUO_BITS-1:0] i_dividend,
    input  logic [DVR_BITS-1:0]          i_divisor,
    output logic                         o_done,
    output logic [QUO_BITS-1:0]          o_quotient
);
    localparam int CNT_BITS = $clog2(QUO_BITS + 1);

    logic [DVR_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0] r_low;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [DVR_BITS:0]   w_trial;
    logic [DVR_BITS:0]   w_diff;
    logic                w_ge;

    always_comb begin
        w_trial = {r_rem, r_low[QUO_BITS-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_ge    = (w_trial >= {1'b0, i_divisor});
    end

    // Payload: partial remainder and the low word that trades dividend bits
    // for quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVR_BITS+QUO_BITS-1:QUO_BITS];
            r_low <= i_dividend[QUO_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVR_BITS-1:0] : w_trial[DVR_BITS-1:0];
            r_low <= {r_low[QUO_BITS-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_BITS'(QUO_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_low;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with empty step count");

endmodule

// ===== rtl/qpp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_dp
// Datapath: sum and difference numerators, scale products, shared divider,
// smoothing state, power scaling and the output register.
// ----------------------------------------------------------------------------
module qpp_dp #(
    parameter int SAMPLE_BITS = qpp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qpp_pkg::t_dp_cmd                     i_cmd,
    output qpp_pkg::t_dp_status                  o_status,
    input  logic [SAMPLE_BITS-1:0]               i_x1_sample,
    input  logic [SAMPLE_BITS-1:0]               i_x2_sample,
    input  logic [SAMPLE_BITS-1:0]               i_y1_sample,
    input  logic [SAMPLE_BITS-1:0]               i_y2_sample,
    input  logic                                 i_cfg_we,
    input  logic [qpp_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [qpp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic signed [qpp_pkg::POS_BITS-1:0]  o_pos_x,
    output logic signed [qpp_pkg::POS_BITS-1:0]  o_pos_y,
    output logic [qpp_pkg::POWER_BITS-1:0]       o_optical_power,
    output logic                                 o_sum_zero
);
    import qpp_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int DVD_BITS = SUM_BITS + FS_BITS;
    localparam int PRD_BITS = SUM_BITS + RATIO_BITS;
    localparam int PSH_BITS = (PRD_BITS - POWER_SHIFT > POWER_BITS) ?
                              PRD_BITS - POWER_SHIFT : POWER_BITS;

    logic [FS_BITS-1:0]     r_full_scale;
    logic [RATIO_BITS-1:0]  r_power_ratio;

    logic [SUM_BITS-1:0]    r_sum;
    logic [SUM_BITS-1:0]    r_mag_x;
    logic [SUM_BITS-1:0]    r_mag_y;
    logic                   r_neg_x;
    logic                   r_neg_y;
    logic                   r_zero;
    logic [DVD_BITS-1:0]    r_dvd_x;
    logic [DVD_BITS-1:0]    r_dvd_y;
    logic [PRD_BITS-1:0]    r_prod_pow;
    logic [FS_BITS-1:0]     r_qx;
    logic [FS_BITS-1:0]     r_qy;

    logic signed [POS_BITS-1:0] r_sx;
    logic signed [POS_BITS-1:0] r_sy;
    logic signed [POS_BITS-1:0] r_pos_x;
    logic signed [POS_BITS-1:0] r_pos_y;
    logic [POWER_BITS-1:0]      r_power;
    logic                       r_sum_zero;

    logic [SUM_BITS-1:0]    w_x1, w_x2, w_y1, w_y2;
    logic [SUM_BITS-1:0]    w_ax, w_bx, w_ay, w_by, w_sum;
    logic                   w_neg_x, w_neg_y;
    logic [DVD_BITS-1:0]    w_dividend;
    logic                   w_div_done;
    logic [FS_BITS-1:0]     w_quot;

    logic signed [POS_BITS-1:0] w_qx_s, w_qy_s, w_px, w_py;
    logic signed [POS_BITS:0]   w_acc_x, w_acc_y;
    logic signed [POS_BITS-1:0] n_sx, n_sy;
    logic [PSH_BITS-1:0]        w_pow_sh;
    logic [POWER_BITS-1:0]      n_power;

    // Numerators: NX = (X2 + Y1) - (X1 + Y2), NY = (X2 + Y2) - (X1 + Y1)
    always_comb begin
        w_x1    = SUM_BITS'(i_x1_sample);
        w_x2    = SUM_BITS'(i_x2_sample);
        w_y1    = SUM_BITS'(i_y1_sample);
        w_y2    = SUM_BITS'(i_y2_sample);
        w_ax    = w_x2 + w_y1;
        w_bx    = w_x1 + w_y2;
        w_ay    = w_x2 + w_y2;
        w_by    = w_x1 + w_y1;
        w_sum   = w_ax + w_bx;
        w_neg_x = (w_bx > w_ax);
        w_neg_y = (w_by > w_ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale  <= FS_RESET;
            r_power_ratio <= RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FULL_SCALE:  r_full_scale  <= i_cfg_data[FS_BITS-1:0];
                CFG_POWER_RATIO: r_power_ratio <= i_cfg_data[RATIO_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sum   <= w_sum;
            r_neg_x <= w_neg_x;
            r_neg_y <= w_neg_y;
            r_mag_x <= w_neg_x ? (w_bx - w_ax) : (w_ax - w_bx);
            r_mag_y <= w_neg_y ? (w_by - w_ay) : (w_ay - w_by);
            r_zero  <= (w_sum == '0);
        end
        if (i_cmd.mul) begin
            r_dvd_x    <= DVD_BITS'(r_mag_x) * DVD_BITS'(r_full_scale);
            r_dvd_y    <= DVD_BITS'(r_mag_y) * DVD_BITS'(r_full_scale);
            r_prod_pow <= PRD_BITS'(r_sum) * PRD_BITS'(r_power_ratio);
        end
        if (i_cmd.take_x) begin
            r_qx <= w_quot;
        end
        if (i_cmd.take_y) begin
            r_qy <= w_quot;
        end
    end

    assign w_dividend = i_cmd.div_sel_y ? r_dvd_y : r_dvd_x;

    qpp_div #(
        .DVR_BITS (SUM_BITS),
        .QUO_BITS (FS_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_sum),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Restore the sign, average with the old state, floor-halve.
    always_comb begin
        w_qx_s  = signed'({1'b0, r_qx});
        w_qy_s  = signed'({1'b0, r_qy});
        w_px    = r_neg_x ? -w_qx_s : w_qx_s;
        w_py    = r_neg_y ? -w_qy_s : w_qy_s;
        w_acc_x = {r_sx[POS_BITS-1], r_sx} + {w_px[POS_BITS-1], w_px};
        w_acc_y = {r_sy[POS_BITS-1], r_sy} + {w_py[POS_BITS-1], w_py};
        n_sx    = r_zero ? r_sx : w_acc_x[POS_BITS:1];
        n_sy    = r_zero ? r_sy : w_acc_y[POS_BITS:1];
        w_pow_sh = PSH_BITS'(r_prod_pow >> POWER_SHIFT);
        if (r_zero) begin
            n_power = '0;
        end else if (w_pow_sh > PSH_BITS'(POWER_MAX)) begin
            n_power = POWER_MAX;
        end else begin
            n_power = w_pow_sh[POWER_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
        end else if (i_cmd.finish) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_pos_x    <= n_sx;
            r_pos_y    <= n_sy;
            r_power    <= n_power;
            r_sum_zero <= r_zero;
        end
    end

    assign o_status.sum_zero = r_zero;
    assign o_status.div_done = w_div_done;

    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_optical_power = r_power;
    assign o_sum_zero      = r_sum_zero;

endmodule

// ===== rtl/qpp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpp_ctrl
// Sequencer: accepts one beat, steps the datapath through multiply and two
// divisions (bar a zero sum), then hands the result to the output register.
// ----------------------------------------------------------------------------
module qpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qpp_pkg::t_dp_cmd    o_cmd,
    input  qpp_pkg::t_dp_status i_status
);
    import qpp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DX_START,
        S_DX_WAIT,
        S_DY_START,
        S_DY_WAIT,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DX_START) || (r_state == S_DY_START);
        o_cmd.div_sel_y = (r_state == S_DY_START);
        o_cmd.take_x    = (r_state == S_DX_WAIT) && i_status.div_done;
        o_cmd.take_y    = (r_state == S_DY_WAIT) && i_status.div_done;
        o_cmd.finish    = (r_state == S_FIN) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_MUL;
                end
                S_MUL: begin
                    // zero sum: skip both divisions
                    r_state <= i_status.sum_zero ? S_FIN : S_DX_START;
                end
                S_DX_START: r_state <= S_DX_WAIT;
                S_DX_WAIT: begin
                    if (i_status.div_done) r_state <= S_DY_START;
                end
                S_DY_START: r_state <= S_DY_WAIT;
                S_DY_WAIT: begin
                    if (i_status.div_done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("result not presented after finish");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DX_WAIT || r_state == S_DY_WAIT))
        else $error("divider done outside a wait state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.finish)
        else $error("output register overwritten while held");

endmodule

// ===== rtl/quad_psd_position_power_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_psd_position_power_top
// Quadrant photodiode position and optical power from four samples.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one beat of four samples
// (X1, X2, Y1, Y2). Output channel: o_out_valid / i_out_stall carry one beat
// of smoothed X and Y position, optical power and the zero-sum flag.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes
// full_scale_um (index 0) or power_ratio (index 1); write only when idle.
// The single radix-2 divider forms the X and then the Y quotient, 13 quotient
// bits each at one bit per cycle. When all four samples are zero, both
// divisions are skipped. The input side stalls while an item is in flight.
// A finished result sits in the output register; if the receiver stalls, the
// block holds the next result in its final state until the register is free,
// and the input stays stalled meanwhile.
// Reset (synchronous, active low) clears the smoothing state to zero, loads
// full_scale_um = 5000 and power_ratio = 256, and empties the output.
// ----------------------------------------------------------------------------
module quad_psd_position_power_top #(
    parameter int SAMPLE_BITS = qpp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [SAMPLE_BITS-1:0]               i_x1_sample,
    input  logic [SAMPLE_BITS-1:0]               i_x2_sample,
    input  logic [SAMPLE_BITS-1:0]               i_y1_sample,
    input  logic [SAMPLE_BITS-1:0]               i_y2_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [qpp_pkg::POS_BITS-1:0]  o_pos_x,
    output logic signed [qpp_pkg::POS_BITS-1:0]  o_pos_y,
    output logic [qpp_pkg::POWER_BITS-1:0]       o_optical_power,
    output logic                                 o_sum_zero,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qpp_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [qpp_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import qpp_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    qpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    qpp_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_x1_sample     (i_x1_sample),
        .i_x2_sample     (i_x2_sample),
        .i_y1_sample     (i_y1_sample),
        .i_y2_sample     (i_y2_sample),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_optical_power (o_optical_power),
        .o_sum_zero      (o_sum_zero)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrant photodiode position and power block.
// A directed table covers dark frames, single-quadrant beams, saturated and
// alternating samples and the scale and ratio extremes. Random phases follow,
// each under its own register settings. Every beat is predicted in the bench
// (sum, differences, scaled quotients, smoothing, power) and checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    import qpp_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int SMP_MAX      = (1 << SB) - 1;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 275;
    localparam int DIR_ROWS     = 26;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SB-1:0] x1;
        logic [SB-1:0] x2;
        logic [SB-1:0] y1;
        logic [SB-1:0] y2;
    } t_quad;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic [POWER_BITS-1:0]      power;
        logic                       sum_zero;
    } t_reading;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_KNOWN, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_quad                    q;
        logic [CFG_DATA_BITS-1:0] fs_data;
        logic [CFG_DATA_BITS-1:0] ratio_data;
        t_reading                 known;
    } t_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [SB-1:0]                     i_x1_sample = '0;
    logic [SB-1:0]                     i_x2_sample = '0;
    logic [SB-1:0]                     i_y1_sample = '0;
    logic [SB-1:0]                     i_y2_sample = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [POS_BITS-1:0]        o_pos_x;
    logic signed [POS_BITS-1:0]        o_pos_y;
    logic [POWER_BITS-1:0]             o_optical_power;
    logic                              o_sum_zero;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]           i_cfg_index = CFG_FULL_SCALE;
    logic [CFG_DATA_BITS-1:0]          i_cfg_data = '0;

    quad_psd_position_power_top #(.SAMPLE_BITS(SB)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_x1_sample     (i_x1_sample),
        .i_x2_sample     (i_x2_sample),
        .i_y1_sample     (i_y1_sample),
        .i_y2_sample     (i_y2_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_optical_power (o_optical_power),
        .o_sum_zero      (o_sum_zero),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the block: registers and smoothing state
    int scale_um  = FS_RESET;
    int ratio_q88 = RATIO_RESET;
    int smooth_x  = 0;
    int smooth_y  = 0;

    t_reading expected_readings[$];
    int       fail_count   = 0;
    int       cycle_count  = 0;
    int       in_idle_pct  = 0;
    int       out_idle_pct = 0;
    int       stall_left   = 0;
    t_row     dir_table [DIR_ROWS];

    // num * scale / sum, truncated toward zero
    function automatic int scaled_pos(int num, int sum);
        int mag;
        int q;
        mag = (num < 0) ? -num : num;
        q = (mag * scale_um) / sum;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_reading predict_reading(t_quad s);
        int       x1, x2, y1, y2, sum;
        longint   pw;
        t_reading r;
        x1 = s.x1;
        x2 = s.x2;
        y1 = s.y1;
        y2 = s.y2;
        sum = x1 + x2 + y1 + y2;
        pw = 0;
        if (sum != 0) begin
            smooth_x = (smooth_x + scaled_pos((x2 + y1) - (x1 + y2), sum)) >>> 1;
            smooth_y = (smooth_y + scaled_pos((x2 + y2) - (x1 + y1), sum)) >>> 1;
            pw = (longint'(sum) * ratio_q88) >> POWER_SHIFT;
            if (pw > POWER_MAX)
                pw = POWER_MAX;
        end
        r.pos_x    = smooth_x[POS_BITS-1:0];
        r.pos_y    = smooth_y[POS_BITS-1:0];
        r.power    = pw[POWER_BITS-1:0];
        r.sum_zero = (sum == 0);
        return r;
    endfunction

    function automatic t_quad make_quad(int x1, int x2, int y1, int y2);
        t_quad s;
        s.x1 = x1[SB-1:0];
        s.x2 = x2[SB-1:0];
        s.y1 = y1[SB-1:0];
        s.y2 = y2[SB-1:0];
        return s;
    endfunction

    function automatic t_row smp_row(int x1, int x2, int y1, int y2);
        t_row r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.q = make_quad(x1, x2, y1, y2);
        return r;
    endfunction

    function automatic t_row known_row(int x1, int x2, int y1, int y2,
                                       int px, int py, int pw, bit zero);
        t_row r;
        r = smp_row(x1, x2, y1, y2);
        r.kind = ROW_KNOWN;
        r.known.pos_x = px[POS_BITS-1:0];
        r.known.pos_y = py[POS_BITS-1:0];
        r.known.power = pw[POWER_BITS-1:0];
        r.known.sum_zero = zero;
        return r;
    endfunction

    function automatic t_row cfg_row(int fs_data, int ratio_data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.fs_data = fs_data[CFG_DATA_BITS-1:0];
        r.ratio_data = ratio_data[CFG_DATA_BITS-1:0];
        return r;
    endfunction

    function automatic t_quad random_quad();
        t_quad s;
        s = '0;
        case ($urandom_range(0, 19))
            0: s = '0;
            1, 2: s = make_quad($urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 3), $urandom_range(0, 3));
            3: begin
                case ($urandom_range(0, 3))
                    0: s.x1 = SB'($urandom_range(1, SMP_MAX));
                    1: s.x2 = SB'($urandom_range(1, SMP_MAX));
                    2: s.y1 = SB'($urandom_range(1, SMP_MAX));
                    default: s.y2 = SB'($urandom_range(1, SMP_MAX));
                endcase
            end
            4: s = make_quad($urandom_range(0, 1) * SMP_MAX, $urandom_range(0, 1) * SMP_MAX,
                             $urandom_range(0, 1) * SMP_MAX, $urandom_range(0, 1) * SMP_MAX);
            default: s = make_quad($urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX),
                                   $urandom_range(0, SMP_MAX), $urandom_range(0, SMP_MAX));
        endcase
        return s;
    endfunction

    // Valid stays high after the beat; settle() or an idle gap in the next call lowers it
    task automatic send_samples(input t_quad s, input bit use_known, input t_reading known);
        t_reading r;
        if ($urandom_range(1, 100) <= in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_x1_sample <= s.x1;
        i_x2_sample <= s.x2;
        i_y1_sample <= s.y1;
        i_y2_sample <= s.y2;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_reading(s);
        expected_readings.push_back(use_known ? known : r);
    endtask

    // Drop valid and hold until every result is out
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_readings.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [CFG_DATA_BITS-1:0] fs_data,
                                  input logic [CFG_DATA_BITS-1:0] ratio_data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FULL_SCALE;
        i_cfg_data  <= fs_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        scale_um = fs_data[FS_BITS-1:0];
        i_cfg_index <= CFG_POWER_RATIO;
        i_cfg_data  <= ratio_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        ratio_q88 = ratio_data[RATIO_BITS-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_reading();
        t_reading want;
        if (expected_readings.size() == 0) begin
            $error("unexpected result: pos_x %0d pos_y %0d power %0d sum_zero %0b",
                   o_pos_x, o_pos_y, o_optical_power, o_sum_zero);
            fail_count++;
            return;
        end
        want = expected_readings.pop_front();
        if (o_pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
            fail_count++;
        end
        if (o_pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
            fail_count++;
        end
        if (o_optical_power !== want.power) begin
            $error("optical_power: expected %0d, got %0d", want.power, o_optical_power);
            fail_count++;
        end
        if (o_sum_zero !== want.sum_zero) begin
            $error("sum_zero: expected %0b, got %0b", want.sum_zero, o_sum_zero);
            fail_count++;
        end
    endtask

    // Result side: check each beat, then stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_reading();
            if (stall_left == 0 && $urandom_range(1, 100) <= out_idle_pct)
                stall_left = $urandom_range(1, 4);
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int    phase;
        int    n;
        int    fs_data;
        int    ratio_data;
        t_quad s;

        dir_table = '{
            known_row(0, 0, 0, 0, 0, 0, 0, 1'b1),
            known_row(0, SMP_MAX, SMP_MAX, 0, 2500, 0, 2047, 1'b0),
            known_row(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, 1250, 0, 4095, 1'b0),
            known_row(0, 0, 0, 0, 1250, 0, 0, 1'b1),
            smp_row(SMP_MAX, 0, 0, 0),
            smp_row(0, 1, 0, 0),
            smp_row(0, 0, 0, SMP_MAX),
            smp_row(0, 0, 1, 0),
            smp_row('hAAA, 'h555, 'hAAA, 'h555),
            smp_row('h555, 'hAAA, 'h555, 'hAAA),
            smp_row(1, 1, 1, 1),
            // full scale masked to 8191, largest ratio
            cfg_row('hFFFF, 'hFFFF),
            smp_row(SMP_MAX, 0, 0, 0),
            smp_row(0, SMP_MAX, 0, SMP_MAX),
            smp_row(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX),
            smp_row(1, 0, 0, 0),
            smp_row(0, 0, 0, 0),
            smp_row(0, SMP_MAX - 1, 1, 0),
            // zero scale with stray upper data bits, zero ratio
            cfg_row('hE000, 0),
            smp_row(0, SMP_MAX, SMP_MAX, 0),
            smp_row(100, 200, 300, 400),
            smp_row(0, 0, 0, 0),
            cfg_row(1, 1),
            smp_row(0, 0, SMP_MAX, 0),
            smp_row(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX),
            cfg_row(FS_RESET, RATIO_RESET)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct  = 25;
        out_idle_pct = 25;
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                settle();
                write_settings(dir_table[i].fs_data, dir_table[i].ratio_data);
            end else begin
                send_samples(dir_table[i].q, dir_table[i].kind == ROW_KNOWN,
                             dir_table[i].known);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    fs_data = 'hFFFF;
                    ratio_data = 'hFFFF;
                end
                2: begin
                    fs_data = $urandom_range(0, 7) << FS_BITS;
                    ratio_data = 0;
                end
                4: begin
                    fs_data = 1;
                    ratio_data = 1;
                end
                default: begin
                    fs_data = $urandom_range(0, 'hFFFF);
                    ratio_data = $urandom_range(0, 'hFFFF);
                end
            endcase
            settle();
            write_settings(CFG_DATA_BITS'(fs_data), CFG_DATA_BITS'(ratio_data));
            // last phase runs flat out on both sides
            if (phase == PHASES - 1) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                s = random_quad();
                send_samples(s, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
